@@ design/grid_neighbourhood_move_diff_core_assert.svh @@
// Assertion macros for the grid neighbourhood move diff core
`ifndef GRID_NEIGHBOURHOOD_MOVE_DIFF_CORE_ASSERT_SVH
`define GRID_NEIGHBOURHOOD_MOVE_DIFF_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define GNMD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gnmd: implication check failed");
// condition must never hold
`define GNMD_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("gnmd: forbidden condition seen");
`else
`define GNMD_ASSERT_IMPL(lbl, ante, cons)
`define GNMD_ASSERT_NEVER(lbl, expr)
`endif
`endif

@@ design/gnmd_pkg.sv @@
// Shared types and constants for the grid neighbourhood move diff core
`timescale 1ns / 1ps
`default_nettype none
package gnmd_pkg;

	localparam int ZONE_W      = 12;
	localparam int CFG_W       = 7;
	localparam int KIND_W      = 2;
	localparam int CNT_W       = 2;
	localparam int TDATA_IN_W  = 24;
	localparam int TDATA_OUT_W = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int MAX_SIDE_DEF = 64;

	localparam logic [CFG_W-1:0] SIDE_RESET = 7'd64;

	localparam logic [KIND_W-1:0] KIND_LEAVE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENTER   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_KEEP    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;

	// clipped 3x3 neighbourhood: top-left id, row count - 1, column count - 1
	typedef struct packed {
		logic [ZONE_W-1:0] start;
		logic [CNT_W-1:0]  rows;
		logic [CNT_W-1:0]  cols;
	} nbhd_t;

	// one classified move handed from front to back
	typedef struct packed {
		logic              inv;
		logic [CFG_W-1:0]  side;
		nbhd_t             old_nb;
		nbhd_t             new_nb;
	} move_t;

	// queue fill status
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage
`default_nettype wire

@@ design/gnmd_front.sv @@
// Front end: config register, input accept, pipelined id-to-row/column split
`timescale 1ns / 1ps
`default_nettype none
module gnmd_front #(
	parameter int MAX_SIDE = gnmd_pkg::MAX_SIDE_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [gnmd_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [gnmd_pkg::TDATA_IN_W-1:0]   s_tdata,
	input  wire gnmd_pkg::queue_stat_t             q_stat,
	output logic                                   push,
	output gnmd_pkg::move_t                        push_entry
);
	localparam int ZONE_W  = gnmd_pkg::ZONE_W;
	localparam int CFG_W   = gnmd_pkg::CFG_W;
	localparam int CNT_W   = gnmd_pkg::CNT_W;
	localparam int CFG_MAX = (2 ** CFG_W) - 1;
	localparam int EFF_MAX = (MAX_SIDE > CFG_MAX) ? CFG_MAX : MAX_SIDE;
	localparam int COORD_W = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
	localparam int NST     = COORD_W;
	localparam int CMP_W   = ZONE_W + CFG_W;
	localparam int TOT_W   = 2 * CFG_W;

	logic [CFG_W-1:0] side_cfg_q;
	logic [CFG_W-1:0] side_eff;
	logic [TOT_W-1:0] total;
	logic [ZONE_W-1:0] in_old, in_new;
	logic in_inv;
	logic adv;

	// pipeline stage registers, stage 0 holds the accepted item
	logic              vld_s   [0:NST];
	logic              inv_s   [0:NST];
	logic [CFG_W-1:0]  side_s  [0:NST];
	logic [ZONE_W-1:0] id_a_s  [0:NST];
	logic [ZONE_W-1:0] id_b_s  [0:NST];
	logic [ZONE_W-1:0] rem_a_s [0:NST];
	logic [ZONE_W-1:0] rem_b_s [0:NST];
	logic [COORD_W-1:0] q_a_s  [0:NST];
	logic [COORD_W-1:0] q_b_s  [0:NST];

	logic [ZONE_W-1:0]  rem_a_nx [0:NST-1];
	logic [ZONE_W-1:0]  rem_b_nx [0:NST-1];
	logic [COORD_W-1:0] q_a_nx   [0:NST-1];
	logic [COORD_W-1:0] q_b_nx   [0:NST-1];

	// clipped neighbourhood from id and its row / column
	function automatic gnmd_pkg::nbhd_t make_nb(
		input logic [ZONE_W-1:0]  id,
		input logic [COORD_W-1:0] row,
		input logic [COORD_W-1:0] col,
		input logic [CFG_W-1:0]   side
	);
		logic up, down, left, right;
		gnmd_pkg::nbhd_t nb;
		up    = (row != '0);
		left  = (col != '0);
		down  = ((CFG_W + 1)'(row) + (CFG_W + 1)'(1)) < (CFG_W + 1)'(side);
		right = ((CFG_W + 1)'(col) + (CFG_W + 1)'(1)) < (CFG_W + 1)'(side);
		nb.start = id - (up ? ZONE_W'(side) : '0) - (left ? ZONE_W'(1) : '0);
		nb.rows  = CNT_W'(up) + CNT_W'(down);
		nb.cols  = CNT_W'(left) + CNT_W'(right);
		return nb;
	endfunction

	// config register, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_cfg_q <= gnmd_pkg::SIDE_RESET;
		end else if (cfg_valid) begin
			side_cfg_q <= cfg_data;
		end
	end

	// effective side and range check
	assign side_eff = (side_cfg_q > CFG_W'(EFF_MAX)) ? CFG_W'(EFF_MAX) : side_cfg_q;
	assign total    = TOT_W'(side_eff) * TOT_W'(side_eff);
	assign in_old   = s_tdata[ZONE_W-1:0];
	assign in_new   = s_tdata[2*ZONE_W-1:ZONE_W];
	assign in_inv   = (side_eff == '0) || (TOT_W'(in_old) >= total)
		|| (TOT_W'(in_new) >= total);

	// whole pipeline stalls only when the last stage cannot push
	assign adv      = !(vld_s[NST] && q_stat.full);
	assign s_tready = adv;

	// one quotient bit per stage, restoring division by side
	always_comb begin
		for (int k = 0; k < NST; k++) begin
			logic [CMP_W-1:0] trial, ra, rb;
			trial = CMP_W'(side_s[k]) << (COORD_W - 1 - k);
			ra    = CMP_W'(rem_a_s[k]);
			rb    = CMP_W'(rem_b_s[k]);
			if (ra >= trial) begin
				rem_a_nx[k] = ZONE_W'(ra - trial);
				q_a_nx[k]   = q_a_s[k] | (COORD_W'(1) << (COORD_W - 1 - k));
			end else begin
				rem_a_nx[k] = rem_a_s[k];
				q_a_nx[k]   = q_a_s[k];
			end
			if (rb >= trial) begin
				rem_b_nx[k] = ZONE_W'(rb - trial);
				q_b_nx[k]   = q_b_s[k] | (COORD_W'(1) << (COORD_W - 1 - k));
			end else begin
				rem_b_nx[k] = rem_b_s[k];
				q_b_nx[k]   = q_b_s[k];
			end
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NST; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= s_tvalid;
			for (int k = 0; k < NST; k++) vld_s[k+1] <= vld_s[k];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			inv_s[0]   <= in_inv;
			side_s[0]  <= side_eff;
			id_a_s[0]  <= in_old;
			id_b_s[0]  <= in_new;
			rem_a_s[0] <= in_old;
			rem_b_s[0] <= in_new;
			q_a_s[0]   <= '0;
			q_b_s[0]   <= '0;
			for (int k = 0; k < NST; k++) begin
				inv_s[k+1]   <= inv_s[k];
				side_s[k+1]  <= side_s[k];
				id_a_s[k+1]  <= id_a_s[k];
				id_b_s[k+1]  <= id_b_s[k];
				rem_a_s[k+1] <= rem_a_nx[k];
				rem_b_s[k+1] <= rem_b_nx[k];
				q_a_s[k+1]   <= q_a_nx[k];
				q_b_s[k+1]   <= q_b_nx[k];
			end
		end
	end

	// classify and hand to the queue
	assign push = vld_s[NST] && adv;
	always_comb begin
		push_entry.inv    = inv_s[NST];
		push_entry.side   = side_s[NST];
		push_entry.old_nb = make_nb(id_a_s[NST], q_a_s[NST], rem_a_s[NST][COORD_W-1:0],
			side_s[NST]);
		push_entry.new_nb = make_nb(id_b_s[NST], q_b_s[NST], rem_b_s[NST][COORD_W-1:0],
			side_s[NST]);
	end

endmodule
`default_nettype wire

@@ design/gnmd_queue.sv @@
// Short queue of classified moves between front and back
`timescale 1ns / 1ps
`default_nettype none
module gnmd_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire gnmd_pkg::move_t       push_entry,
	input  wire logic                  pop,
	output gnmd_pkg::move_t            head,
	output gnmd_pkg::queue_stat_t      q_stat
);
	localparam int DEPTH = gnmd_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gnmd_pkg::move_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ design/gnmd_back.sv @@
// Back end: walks both neighbourhoods, merges them and drives the result stream
`timescale 1ns / 1ps
`default_nettype none
module gnmd_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire gnmd_pkg::move_t                    head,
	input  wire gnmd_pkg::queue_stat_t              q_stat,
	output logic                                    pop,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [gnmd_pkg::TDATA_OUT_W-1:0]        m_tdata,
	output logic [gnmd_pkg::KIND_W-1:0]             m_tuser,
	output logic                                    m_tlast
);
	localparam int ZONE_W = gnmd_pkg::ZONE_W;
	localparam int CFG_W  = gnmd_pkg::CFG_W;
	localparam int CNT_W  = gnmd_pkg::CNT_W;
	localparam int KIND_W = gnmd_pkg::KIND_W;

	// walker over one clipped neighbourhood in ascending order
	typedef struct packed {
		logic              act;
		logic [ZONE_W-1:0] cur;
		logic [ZONE_W-1:0] rstart;
		logic [CNT_W-1:0]  crem;
		logic [CNT_W-1:0]  creload;
		logic [CNT_W-1:0]  rrem;
	} walk_t;

	logic             busy_q, inv_q;
	logic [CFG_W-1:0] side_q;
	walk_t            wa_q, wb_q;
	logic              out_valid_q, out_last_q;
	logic [ZONE_W-1:0] out_zone_q;
	logic [KIND_W-1:0] out_kind_q;

	logic out_space, emit, take_a, take_b, a_end, b_end;
	logic res_last;
	logic [ZONE_W-1:0] res_zone;
	logic [KIND_W-1:0] res_kind;

	function automatic walk_t walk_init(input gnmd_pkg::nbhd_t nb);
		walk_t w;
		w.act     = 1'b1;
		w.cur     = nb.start;
		w.rstart  = nb.start;
		w.crem    = nb.cols;
		w.creload = nb.cols;
		w.rrem    = nb.rows;
		return w;
	endfunction

	// next column, else first column of the next row, else done
	function automatic walk_t walk_step(input walk_t w, input logic [CFG_W-1:0] side);
		walk_t n;
		n = w;
		if (w.crem != '0) begin
			n.cur  = w.cur + ZONE_W'(1);
			n.crem = w.crem - CNT_W'(1);
		end else if (w.rrem != '0) begin
			n.cur    = w.rstart + ZONE_W'(side);
			n.rstart = w.rstart + ZONE_W'(side);
			n.crem   = w.creload;
			n.rrem   = w.rrem - CNT_W'(1);
		end else begin
			n.act = 1'b0;
		end
		return n;
	endfunction

	assign out_space = !out_valid_q || m_tready;
	assign emit      = busy_q && out_space;
	assign a_end     = (wa_q.rrem == '0) && (wa_q.crem == '0);
	assign b_end     = (wb_q.rrem == '0) && (wb_q.crem == '0);

	// merge step: smaller head goes out, equal heads together; invalid: one result
	always_comb begin
		take_a   = 1'b0;
		take_b   = 1'b0;
		res_zone = '0;
		res_kind = gnmd_pkg::KIND_INVALID;
		res_last = 1'b1;
		if (!inv_q) begin
			take_a   = wa_q.act && (!wb_q.act || (wa_q.cur <= wb_q.cur));
			take_b   = wb_q.act && (!wa_q.act || (wb_q.cur <= wa_q.cur));
			res_zone = take_a ? wa_q.cur : wb_q.cur;
			if (take_a && take_b) begin
				res_kind = gnmd_pkg::KIND_KEEP;
			end else if (take_a) begin
				res_kind = gnmd_pkg::KIND_LEAVE;
			end else begin
				res_kind = gnmd_pkg::KIND_ENTER;
			end
			res_last = (!wa_q.act || (take_a && a_end)) && (!wb_q.act || (take_b && b_end));
		end
	end

	// next move loads while the current one hands out its final result
	assign pop = !q_stat.empty && (!busy_q || (emit && res_last));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (emit && res_last) begin
				busy_q <= 1'b0;
			end
			if (out_space) begin
				out_valid_q <= emit;
			end
		end
	end

	// walkers and output register
	always_ff @(posedge clk) begin
		if (pop) begin
			inv_q  <= head.inv;
			side_q <= head.side;
			wa_q   <= walk_init(head.old_nb);
			wb_q   <= walk_init(head.new_nb);
		end else if (emit) begin
			if (take_a) wa_q <= walk_step(wa_q, side_q);
			if (take_b) wb_q <= walk_step(wb_q, side_q);
		end
		if (emit) begin
			out_zone_q <= res_zone;
			out_kind_q <= res_kind;
			out_last_q <= res_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(gnmd_pkg::TDATA_OUT_W - ZONE_W){1'b0}}, out_zone_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

@@ design/grid_neighbourhood_move_diff_core.sv @@
// Top level of the grid neighbourhood move diff core
// Usage:
//   s_* stream: one transaction carries a move (old zone id, new zone id).
//   m_* stream: one transaction per affected zone in ascending id order, kind in
//     tuser (leave, enter, keep, invalid), tlast on the final result of a move.
//   cfg_*: writes zones_per_side; always ready, write only while idle.
// Timing:
//   The front splits each id into row and column in a pipeline of
//   clog2(side limit) division stages (6 at the default limit of 64), then
//   queues the move. The back emits one result per cycle while it holds a
//   move and m_tready does not hold it back; a move gives 1 to 18 results,
//   and the next queued move loads into the walkers at the same edge that
//   registers the final result of the previous one.
// Reset: clears all valid state; zones_per_side returns to 64.
// Stall: m_tready low holds the result register; the back stops, the queue
//   fills and the front pipeline then holds, dropping s_tready.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_neighbourhood_move_diff_core_assert.svh"
module grid_neighbourhood_move_diff_core #(
	parameter int MAX_SIDE = gnmd_pkg::MAX_SIDE_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// config write: zones_per_side [6:0]
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [gnmd_pkg::CFG_W-1:0]        cfg_data,
	// tdata: old_zone [11:0], new_zone [23:12]
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [gnmd_pkg::TDATA_IN_W-1:0]   s_tdata,
	// tdata: zone [11:0], zero fill [15:12]
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [gnmd_pkg::TDATA_OUT_W-1:0]       m_tdata,
	// tuser: kind [1:0]
	output logic [gnmd_pkg::KIND_W-1:0]            m_tuser,
	output logic                                   m_tlast
);
	logic                  push, pop;
	gnmd_pkg::move_t       push_entry, head;
	gnmd_pkg::queue_stat_t q_stat;

	gnmd_front #(
		.MAX_SIDE (MAX_SIDE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	gnmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	gnmd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// front holds off input only when the queue is full
	`GNMD_ASSERT_IMPL(a_stall_only_when_full, !s_tready, q_stat.full)
	`GNMD_ASSERT_NEVER(a_queue_overflow, push && q_stat.full)
	`GNMD_ASSERT_NEVER(a_queue_underflow, pop && q_stat.empty)
	// an invalid move is a single zero result
	`GNMD_ASSERT_IMPL(a_invalid_single, m_tvalid && (m_tuser == gnmd_pkg::KIND_INVALID), m_tlast && (m_tdata == '0))

endmodule
`default_nettype wire
